// ----- rtl/bldf_pkg.sv -----
// Shared types, constants and the duty curve table of the backlight fade engine.
// Used by bldf_div, bldf_mul and backlight_fade_smoothstep; depends on nothing else.
`default_nettype none

package bldf_pkg;

   // Field widths of the transactions.
   localparam int OP_BITS     = 2;
   localparam int REQ_LVL_BITS = 8;
   localparam int DUR_BITS    = 16;
   localparam int PCT_BITS    = 7;
   localparam int DUTY_BITS   = 8;

   // Default width of the fade length and elapsed tick counters.
   localparam int LENGTH_BITS_DEF = 16;

   // Easing arithmetic: k is Q0.16, the smoothstep value is Q0.48.
   localparam int FRAC_BITS   = 16;
   localparam int SMOOTH_BITS = 3 * FRAC_BITS;
   localparam int MPLIER_BITS = FRAC_BITS + 2;
   localparam int PROD_BITS   = SMOOTH_BITS + 8;
   localparam int PART_BITS   = PROD_BITS - SMOOTH_BITS;
   localparam int STEP_BITS   = 5;

   localparam logic [MPLIER_BITS-1:0] SMOOTH_THREE = MPLIER_BITS'(3 * (1 << FRAC_BITS));
   localparam logic [PCT_BITS-1:0]    MAX_PCT      = PCT_BITS'(100);

   // Operation codes.
   localparam logic [OP_BITS-1:0] OP_TICK = 2'd0;
   localparam logic [OP_BITS-1:0] OP_SET  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_FADE = 2'd2;

   // Duty curve: floor(level * level * 255 / 10000).
   localparam int DUTY_SCALE   = 255;
   localparam int DUTY_DIV     = 10000;
   localparam int DUTY_ENTRIES = 1 << PCT_BITS;

   typedef logic [DUTY_ENTRIES-1:0][DUTY_BITS-1:0] duty_table_type;

   function automatic duty_table_type duty_table_build();
      duty_table_type t;
      for (int i = 0; i < DUTY_ENTRIES; i++) begin
         t[i] = DUTY_BITS'((i * i * DUTY_SCALE) / DUTY_DIV);
      end
      return t;
   endfunction

   localparam duty_table_type DUTY_TABLE = duty_table_build();

   typedef struct packed {
      logic [OP_BITS-1:0]      op;
      logic [REQ_LVL_BITS-1:0] level;
      logic [DUR_BITS-1:0]     duration_ms;
   } req_type;

   typedef struct packed {
      logic [PCT_BITS-1:0]  current_level;
      logic [DUTY_BITS-1:0] pwm_duty;
      logic                 busy_res;
   } rsp_type;

   typedef struct packed {
      logic                   done;
      logic [FRAC_BITS-1:0]   quotient;
   } div_sts_type;

   typedef struct packed {
      logic                   start;
      logic [PROD_BITS-1:0]   mcand;
      logic [MPLIER_BITS-1:0] mplier;
      logic [STEP_BITS-1:0]   steps;
   } mul_cmd_type;

   typedef struct packed {
      logic                 done;
      logic [PROD_BITS-1:0] product;
   } mul_sts_type;

endpackage

`default_nettype wire

// ----- rtl/bldf_div.sv -----
// Bit-serial restoring divider: one quotient bit of the Q0.16 fade fraction per cycle.
// Depends on bldf_pkg.
`default_nettype none

module bldf_div #(
   parameter int LENGTH_BITS = bldf_pkg::LENGTH_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [LENGTH_BITS-1:0] dividend,
   input  wire logic [LENGTH_BITS-1:0] divisor,
   output bldf_pkg::div_sts_type       sts
);

   logic [LENGTH_BITS-1:0]           rem_ff, rem_in;
   logic [LENGTH_BITS-1:0]           dvs_ff, dvs_in;
   logic [bldf_pkg::FRAC_BITS-1:0]   quo_ff, quo_in;
   logic [bldf_pkg::STEP_BITS-1:0]   cnt_ff, cnt_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [LENGTH_BITS:0]             trial;
   logic [LENGTH_BITS:0]             diff;
   logic                             fits;

   // The remainder stays below the divisor, so the doubled trial fits one extra bit.
   assign trial = {rem_ff, 1'b0};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = bldf_pkg::STEP_BITS'(bldf_pkg::FRAC_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[LENGTH_BITS-1:0] : trial[LENGTH_BITS-1:0];
         quo_in = {quo_ff[bldf_pkg::FRAC_BITS-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == bldf_pkg::STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

endmodule

`default_nettype wire

// ----- rtl/bldf_mul.sv -----
// Bit-serial shift-and-add multiplier shared by the three products of the easing curve.
// Depends on bldf_pkg.
`default_nettype none

module bldf_mul (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bldf_pkg::mul_cmd_type cmd,
   output bldf_pkg::mul_sts_type      sts
);

   logic [bldf_pkg::PROD_BITS-1:0]   acc_ff, acc_in;
   logic [bldf_pkg::PROD_BITS-1:0]   mcand_ff, mcand_in;
   logic [bldf_pkg::MPLIER_BITS-1:0] mplier_ff, mplier_in;
   logic [bldf_pkg::STEP_BITS-1:0]   cnt_ff, cnt_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;

   // Bits shifted out of the multiplicand never matter: every true product fits the
   // accumulator, so arithmetic modulo its width gives the exact result.
   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (cmd.start) begin
         acc_in    = '0;
         mcand_in  = cmd.mcand;
         mplier_in = cmd.mplier;
         cnt_in    = cmd.steps;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         acc_in    = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
         mcand_in  = {mcand_ff[bldf_pkg::PROD_BITS-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[bldf_pkg::MPLIER_BITS-1:1]};
         cnt_in    = cnt_ff - 1'b1;
         if (cnt_ff == bldf_pkg::STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff    <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.done    = done_ff;
   assign sts.product = acc_ff;

endmodule

`default_nettype wire

// ----- rtl/backlight_fade_smoothstep.sv -----
// Backlight level engine: one transaction in, one result transaction out. A set, a fade
// start, an unused code, a tick with no fade running or the tick that ends a fade goes
// straight to registering its result. A tick that advances a fade short of its end first
// runs a serial divide for the fade fraction k, then three bit-serial products on one
// shared multiplier (k*k, times the level distance, times 3-2k), with a handoff between
// units; then the level is applied, the result registered and the next request taken.
// The result sits in an output register, so the next request is taken while a result
// waits on rsp_stall; a new result waits as long as that register stays full.
// Depends on bldf_pkg, bldf_div and bldf_mul.
`default_nettype none

module backlight_fade_smoothstep #(
   parameter int LENGTH_BITS = bldf_pkg::LENGTH_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire bldf_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output bldf_pkg::rsp_type      rsp_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_SQR  = 3'd2;
   localparam logic [2:0] ST_SCL  = 3'd3;
   localparam logic [2:0] ST_EASE = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   logic [2:0]                      state_ff, state_in;
   logic [bldf_pkg::PCT_BITS-1:0]   now_ff, now_in;
   logic [bldf_pkg::PCT_BITS-1:0]   start_ff, start_in;
   logic [bldf_pkg::PCT_BITS-1:0]   target_ff, target_in;
   logic [LENGTH_BITS-1:0]          elapsed_ff, elapsed_in;
   logic [LENGTH_BITS-1:0]          fade_ff, fade_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   bldf_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic                            accept;
   logic                            out_free;
   logic [bldf_pkg::PCT_BITS-1:0]   clamped;
   logic [LENGTH_BITS-1:0]          dur;
   logic [LENGTH_BITS-1:0]          elapsed_inc;
   logic                            rising;
   logic [bldf_pkg::PCT_BITS-1:0]   lvl_gap;
   logic [bldf_pkg::PART_BITS-1:0]  part;
   logic                            div_start;
   bldf_pkg::div_sts_type           div_sts;
   bldf_pkg::mul_cmd_type           mul_cmd;
   bldf_pkg::mul_sts_type           mul_sts;

   assign accept      = req_valid && !req_stall;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign clamped     = (req_data.level > bldf_pkg::REQ_LVL_BITS'(bldf_pkg::MAX_PCT)) ?
                        bldf_pkg::MAX_PCT : req_data.level[bldf_pkg::PCT_BITS-1:0];
   assign dur         = LENGTH_BITS'(req_data.duration_ms);
   assign elapsed_inc = elapsed_ff + 1'b1;
   assign rising      = target_ff >= start_ff;
   assign lvl_gap     = rising ? (target_ff - start_ff) : (start_ff - target_ff);

   // Falling fades round the eased step up so that both directions floor the level.
   assign part = mul_sts.product[bldf_pkg::PROD_BITS-1:bldf_pkg::SMOOTH_BITS] +
                 bldf_pkg::PART_BITS'(!rising &&
                                      (|mul_sts.product[bldf_pkg::SMOOTH_BITS-1:0]));

   bldf_div #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(elapsed_inc),
      .divisor (fade_ff),
      .sts     (div_sts)
   );

   bldf_mul u_mul (
      .clock(clock),
      .reset(reset),
      .cmd  (mul_cmd),
      .sts  (mul_sts)
   );

   always_comb begin
      state_in     = state_ff;
      now_in       = now_ff;
      start_in     = start_ff;
      target_in    = target_ff;
      elapsed_in   = elapsed_ff;
      fade_in      = fade_ff;
      div_start    = 1'b0;
      mul_cmd.start  = 1'b0;
      mul_cmd.mcand  = mul_sts.product;
      mul_cmd.mplier = bldf_pkg::MPLIER_BITS'(lvl_gap);
      mul_cmd.steps  = bldf_pkg::STEP_BITS'(bldf_pkg::PCT_BITS);
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_FIN;
               case (req_data.op)
                  bldf_pkg::OP_TICK: begin
                     if (fade_ff != '0) begin
                        elapsed_in = elapsed_inc;
                        if (elapsed_inc >= fade_ff) begin
                           fade_in = '0;
                           now_in  = target_ff;
                        end else begin
                           div_start = 1'b1;
                           state_in  = ST_DIV;
                        end
                     end
                  end
                  bldf_pkg::OP_SET: begin
                     fade_in = '0;
                     now_in  = clamped;
                  end
                  bldf_pkg::OP_FADE: begin
                     if (dur == '0) begin
                        fade_in = '0;
                        now_in  = clamped;
                     end else begin
                        start_in   = now_ff;
                        target_in  = clamped;
                        elapsed_in = '0;
                        fade_in    = dur;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               mul_cmd.start  = 1'b1;
               mul_cmd.mcand  = bldf_pkg::PROD_BITS'(div_sts.quotient);
               mul_cmd.mplier = bldf_pkg::MPLIER_BITS'(div_sts.quotient);
               mul_cmd.steps  = bldf_pkg::STEP_BITS'(bldf_pkg::FRAC_BITS);
               state_in       = ST_SQR;
            end
         end
         ST_SQR: begin
            if (mul_sts.done) begin
               mul_cmd.start = 1'b1;
               state_in      = ST_SCL;
            end
         end
         ST_SCL: begin
            if (mul_sts.done) begin
               mul_cmd.start  = 1'b1;
               mul_cmd.mplier = bldf_pkg::SMOOTH_THREE -
                                bldf_pkg::MPLIER_BITS'({div_sts.quotient, 1'b0});
               mul_cmd.steps  = bldf_pkg::STEP_BITS'(bldf_pkg::MPLIER_BITS);
               state_in       = ST_EASE;
            end
         end
         ST_EASE: begin
            if (mul_sts.done) begin
               now_in   = rising ? (start_ff + part[bldf_pkg::PCT_BITS-1:0]) :
                                   (start_ff - part[bldf_pkg::PCT_BITS-1:0]);
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_data_in.current_level = now_ff;
               rsp_data_in.pwm_duty      = bldf_pkg::DUTY_TABLE[now_ff];
               rsp_data_in.busy_res      = fade_ff != '0;
               rsp_valid_in              = 1'b1;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         start_ff     <= '0;
         target_ff    <= '0;
         elapsed_ff   <= '0;
         fade_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         start_ff     <= start_in;
         target_ff    <= target_in;
         elapsed_ff   <= elapsed_in;
         fade_ff      <= fade_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      now_ff <= bldf_pkg::MAX_PCT)
      else $error("applied level exceeds full scale");

   a_elapsed_below_length: assert property (@(posedge clock) disable iff (reset)
      (fade_ff != '0) |-> (elapsed_ff < fade_ff))
      else $error("fade kept running past its length");

   a_step_within_distance: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EASE && mul_sts.done) |-> (part <= bldf_pkg::PART_BITS'(lvl_gap)))
      else $error("eased step overshoots the fade distance");

   a_mul_done_in_sequence: assert property (@(posedge clock) disable iff (reset)
      mul_sts.done |-> (state_ff == ST_SQR || state_ff == ST_SCL || state_ff == ST_EASE))
      else $error("multiplier finished outside the easing sequence");
`endif

endmodule

`default_nettype wire
